// File: src/gpa_pkg.sv
package gpa_pkg;

	// Image geometry and store size.
	localparam int MAX_WIDTH   = 64;
	localparam int MAX_HEIGHT  = 64;
	localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int TOTAL_W     = ADDR_W + 1;

	// Field widths fixed by the interface.
	localparam int DIM_W      = 7;
	localparam int PIX_W      = 8;
	localparam int COUNT_BITS = 16;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 8;

	// Arithmetic widths of the weighted average.
	localparam int PROD_W = COUNT_BITS + PIX_W;
	localparam int NUM_W  = PROD_W + 1;
	localparam int DEN_W  = COUNT_BITS + 1;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic [PIX_W-1:0]      PIX_MAX   = '1;
	localparam logic [PIX_W-1:0]      PIX_ZERO  = '0;

	// Reset values of the configuration registers.
	localparam logic [DIM_W-1:0] WIDTH_RESET     = DIM_W'(64);
	localparam logic [DIM_W-1:0] HEIGHT_RESET    = DIM_W'(64);
	localparam logic [PIX_W-1:0] THRESHOLD_RESET = PIX_W'(200);

	// Pipeline stage numbers: one restoring step per quotient bit.
	localparam int ST_DIV_FIRST = 3;
	localparam int ST_LAST      = ST_DIV_FIRST + PIX_W;

	// Configuration register indexes.
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_IMAGE_WIDTH  = 2'd0,
		REG_IMAGE_HEIGHT = 2'd1,
		REG_THRESHOLD    = 2'd2
	} cfg_reg_t;

	// Item kinds.
	localparam logic KIND_ADD   = 1'b0;
	localparam logic KIND_MERGE = 1'b1;

	// Control data that travels with an item down the pipeline.
	typedef struct packed {
		logic                  kind;
		logic [PIX_W-1:0]      pix;
		logic                  bypass;
		logic                  last;
		logic [ADDR_W-1:0]     addr;
		logic [COUNT_BITS-1:0] count_new;
	} side_t;

	// Clamp a geometry register to 1..maxv.
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
		input logic [DIM_W-1:0] maxv);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (v > maxv) begin
			r = maxv;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

// File: src/gpa_channels.sv
// Input channel: one pixel item of a sample or pattern image.
interface gpa_in_if;
	logic                          valid;
	logic                          ready;
	logic                          kind;
	logic [gpa_pkg::PIX_W-1:0]      pixel_value;
	logic [gpa_pkg::COUNT_BITS-1:0] other_count;

	modport source (output valid, kind, pixel_value, other_count, input ready);
	modport sink (input valid, kind, pixel_value, other_count, output ready);
endinterface

// Output channel: one updated prototype pixel.
interface gpa_out_if;
	logic                          valid;
	logic                          ready;
	logic [gpa_pkg::PIX_W-1:0]      pixel_out;
	logic [gpa_pkg::COUNT_BITS-1:0] sample_count;
	logic                          end_of_image;

	modport source (output valid, pixel_out, sample_count, end_of_image, input ready);
	modport sink (input valid, pixel_out, sample_count, end_of_image, output ready);
endinterface

// File: src/glyph_prototype_averager.sv
// Throughput: one item per cycle while the result channel is not stalled; the store
// read at acceptance waits while an item for the same position is still in the
// 11-stage pipeline, so images of fewer than 12 pixels are slowed by these waits.
// Reset clears control state, the sample count and the raster position, and sets the
// configuration registers to their reset values; the prototype store is not cleared.
module glyph_prototype_averager (
	input  logic                             clk,
	input  logic                             arst_n,
	gpa_in_if.sink                           sample,
	gpa_out_if.source                        result,
	input  logic                             cfg_we,
	input  logic [gpa_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [gpa_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int AW  = gpa_pkg::ADDR_W;
	localparam int CB  = gpa_pkg::COUNT_BITS;
	localparam int PW  = gpa_pkg::PIX_W;
	localparam int NW  = gpa_pkg::NUM_W;
	localparam int DW  = gpa_pkg::DEN_W;
	localparam int DF  = gpa_pkg::ST_DIV_FIRST;
	localparam int SL  = gpa_pkg::ST_LAST;

	// Configuration and sequencing state.
	logic [gpa_pkg::DIM_W-1:0] width_q;
	logic [gpa_pkg::DIM_W-1:0] height_q;
	logic [PW-1:0]             threshold_q;
	logic [CB-1:0]             count_q;
	logic [AW-1:0]             pos_q;

	// Prototype store.
	logic [PW-1:0] mem [0:gpa_pkg::STORE_DEPTH-1];
	logic [PW-1:0] rdata_s1;

	// Pipeline registers.
	logic                valid_s [1:SL];
	gpa_pkg::side_t      side_s  [1:SL];
	logic [CB-1:0]       cnt_s1;
	logic [CB-1:0]       other_s1;
	logic [gpa_pkg::PROD_W-1:0] proda_s2;
	logic [gpa_pkg::PROD_W-1:0] prodb_s2;
	logic [DW-1:0]       den_s   [2:SL];
	logic [NW-1:0]       rem_s   [DF:SL];
	logic [PW-1:0]       q_s     [DF:SL];

	// Output register.
	logic          out_valid_q;
	logic [PW-1:0] out_pixel_q;
	logic [CB-1:0] out_count_q;
	logic          out_eoi_q;

	// Combinational signals.
	logic [gpa_pkg::DIM_W-1:0] w_c;
	logic [gpa_pkg::DIM_W-1:0] h_c;
	logic [gpa_pkg::TOTAL_W-1:0] total_c;
	logic                last_c;
	logic                adv;
	logic                hazard;
	logic                accept;
	logic [CB-1:0]       inc_c;
	logic [CB:0]         sum_c;
	logic [CB-1:0]       count_next_c;
	logic [CB-1:0]       weight_c;
	logic [NW-1:0]       trial_c [DF:SL-1];
	logic [NW-1:0]       rem_nx  [DF:SL-1];
	logic [PW-1:0]       q_nx    [DF:SL-1];
	logic [PW-1:0]       res_c;

	// Geometry in use and end of image detection.
	always_comb begin
		w_c     = gpa_pkg::clamp_dim(width_q, gpa_pkg::DIM_W'(gpa_pkg::MAX_WIDTH));
		h_c     = gpa_pkg::clamp_dim(height_q, gpa_pkg::DIM_W'(gpa_pkg::MAX_HEIGHT));
		total_c = gpa_pkg::TOTAL_W'(w_c) * gpa_pkg::TOTAL_W'(h_c);
		last_c  = (gpa_pkg::TOTAL_W'(pos_q) + gpa_pkg::TOTAL_W'(1)) >= total_c;
	end

	// The pipeline moves as a whole whenever the output register can take an item.
	assign adv = !out_valid_q || result.ready;

	// A store read must not pass a pending write to the same position.
	always_comb begin
		hazard = 1'b0;
		for (int st = 1; st <= SL; st++) begin
			if (valid_s[st] && (side_s[st].addr == pos_q)) begin
				hazard = 1'b1;
			end
		end
	end

	assign sample.ready = adv && !hazard;
	assign accept       = sample.valid && sample.ready;

	// Count after this item: it grows only on the final pixel and saturates.
	always_comb begin
		inc_c = (sample.kind == gpa_pkg::KIND_ADD) ? CB'(1) : sample.other_count;
		sum_c = {1'b0, count_q} + {1'b0, inc_c};
		if (!last_c) begin
			count_next_c = count_q;
		end else if (sum_c[CB]) begin
			count_next_c = gpa_pkg::COUNT_MAX;
		end else begin
			count_next_c = sum_c[CB-1:0];
		end
	end

	// Configuration writes, raster position and sample count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= gpa_pkg::WIDTH_RESET;
			height_q    <= gpa_pkg::HEIGHT_RESET;
			threshold_q <= gpa_pkg::THRESHOLD_RESET;
			count_q     <= '0;
			pos_q       <= '0;
		end else if (cfg_we) begin
			unique case (gpa_pkg::cfg_reg_t'(cfg_index))
				gpa_pkg::REG_IMAGE_WIDTH: begin
					width_q <= cfg_data[gpa_pkg::DIM_W-1:0];
					pos_q   <= '0;
				end
				gpa_pkg::REG_IMAGE_HEIGHT: begin
					height_q <= cfg_data[gpa_pkg::DIM_W-1:0];
					pos_q    <= '0;
				end
				gpa_pkg::REG_THRESHOLD: begin
					threshold_q <= cfg_data[PW-1:0];
				end
				default: begin
				end
			endcase
		end else if (accept) begin
			count_q <= count_next_c;
			pos_q   <= last_c ? '0 : pos_q + AW'(1);
		end
	end

	// Restoring division, one quotient bit per stage.
	always_comb begin
		for (int st = DF; st < SL; st++) begin
			trial_c[st] = NW'(den_s[st]) << (SL - 1 - st);
			if (rem_s[st] >= trial_c[st]) begin
				rem_nx[st] = rem_s[st] - trial_c[st];
				q_nx[st]   = q_s[st] | (PW'(1) << (SL - 1 - st));
			end else begin
				rem_nx[st] = rem_s[st];
				q_nx[st]   = q_s[st];
			end
		end
	end

	assign weight_c = (side_s[1].kind == gpa_pkg::KIND_ADD) ? CB'(1) : other_s1;

	// Valid bits of the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int st = 1; st <= SL; st++) begin
				valid_s[st] <= 1'b0;
			end
		end else if (adv) begin
			valid_s[1] <= accept;
			for (int st = 2; st <= SL; st++) begin
				valid_s[st] <= valid_s[st-1];
			end
		end
	end

	// Pipeline payload: capture, products, numerator, then the divider steps.
	// A copy is taken when the count is zero and the item adds a sample or
	// merges a pattern of zero weight.
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s[1] <= '{
				kind:      sample.kind,
				pix:       sample.pixel_value,
				bypass:    (count_q == '0) && ((sample.kind == gpa_pkg::KIND_ADD) ||
					(sample.other_count == '0)),
				last:      last_c,
				addr:      pos_q,
				count_new: count_next_c
			};
			cnt_s1              <= count_q;
			other_s1            <= sample.other_count;

			side_s[2] <= side_s[1];
			// An empty prototype contributes nothing, whatever the store holds.
			proda_s2  <= (cnt_s1 == '0) ? '0 : cnt_s1 * rdata_s1;
			prodb_s2  <= weight_c * side_s[1].pix;
			den_s[2]  <= DW'(cnt_s1) + DW'(weight_c);

			side_s[DF] <= side_s[DF-1];
			den_s[DF]  <= den_s[DF-1];
			rem_s[DF]  <= NW'(proda_s2) + NW'(prodb_s2);
			q_s[DF]    <= '0;

			for (int st = DF; st < SL; st++) begin
				side_s[st+1] <= side_s[st];
				den_s[st+1]  <= den_s[st];
				rem_s[st+1]  <= rem_nx[st];
				q_s[st+1]    <= q_nx[st];
			end
		end
	end

	// Final value: copy, binarized average or plain weighted average.
	always_comb begin
		if (side_s[SL].bypass) begin
			res_c = side_s[SL].pix;
		end else if (side_s[SL].kind == gpa_pkg::KIND_ADD) begin
			res_c = (q_s[SL] > threshold_q) ? gpa_pkg::PIX_MAX : gpa_pkg::PIX_ZERO;
		end else begin
			res_c = q_s[SL];
		end
	end

	// Store access: read at acceptance, write back as the item leaves the pipeline.
	always_ff @(posedge clk) begin
		if (adv) begin
			rdata_s1 <= mem[pos_q];
			if (valid_s[SL]) begin
				mem[side_s[SL].addr] <= res_c;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s[SL];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_pixel_q <= res_c;
			out_count_q <= side_s[SL].count_new;
			out_eoi_q   <= side_s[SL].last;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.pixel_out    = out_pixel_q;
	assign result.sample_count = out_count_q;
	assign result.end_of_image = out_eoi_q;

	// The raster position always lies inside the image in use.
	a_pos_in_image: assert property (@(posedge clk) disable iff (!arst_n)
		gpa_pkg::TOTAL_W'(pos_q) < total_c)
		else $error("raster position outside the image");

	// The divider leaves a remainder below the divisor unless the item is a copy.
	a_div_remainder: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s[SL] |-> (side_s[SL].bypass || (rem_s[SL] < NW'(den_s[SL]))))
		else $error("division did not converge");

	// An accepted item never reads the position being written back in the same cycle.
	a_no_read_during_write: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && adv && valid_s[SL]) |-> (side_s[SL].addr != pos_q))
		else $error("store read collides with write back");

	// The sample count never decreases.
	a_count_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (count_q >= $past(count_q)))
		else $error("sample count decreased");

endmodule
